[rtl/rsmf_pkg.sv]
package rsmf_pkg;

  localparam int SAMPLE_W = 16;

  typedef logic [SAMPLE_W-1:0] sample_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_MAX_VALID_RANGE = 1'b0,
    REG_INVALID_CODE    = 1'b1
  } reg_idx_t;

  localparam sample_t MAX_VALID_RANGE_RST = 16'd2200;
  localparam sample_t INVALID_CODE_RST    = 16'd9999;

endpackage

[rtl/rsmf_cell.sv]
module rsmf_cell import rsmf_pkg::*; #(
  parameter int WINDOW_LEN = 5,
  parameter int POS        = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          shift_en,
  input  sample_t                       shift_in,
  input  logic [WINDOW_LEN-1:0][SAMPLE_W-1:0] window,
  output sample_t                       sample,
  output logic                          median_hit
);

  localparam int RANK_W = $clog2(WINDOW_LEN);
  localparam int MID    = (WINDOW_LEN - 1) / 2;

  logic [RANK_W-1:0] rank;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample <= '0;
    end else if (shift_en) begin
      sample <= shift_in;
    end
  end

  // Rank = number of entries ordered ahead of this one; equal values are
  // ordered by position so every rank is taken exactly once.
  always_comb begin
    rank = '0;
    for (int j = 0; j < WINDOW_LEN; j++) begin
      if (j != POS) begin
        if ((window[j] < sample) || ((window[j] == sample) && (j < POS))) begin
          rank = rank + RANK_W'(1);
        end
      end
    end
  end

  assign median_hit = (rank == RANK_W'(MID));

endmodule

[rtl/range_sample_median_filter_core.sv]
// Sliding-window median of range samples. One request is taken per clock
// while the output side keeps up. Each reading is qualified and shifted
// into the row of window cells; in the next step every cell ranks its
// sample against the whole window and the cell holding the middle rank
// drives the output register with the median.
// A stall on m_tready holds the whole path. The window is zero after reset,
// so the first medians count those zeros. Write the configuration
// registers only while no request is in flight.
module range_sample_median_filter_core import rsmf_pkg::*; #(
  parameter int WINDOW_LEN = 5
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] raw_range
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [15:0] median_range
);

  sample_t max_valid_range;
  sample_t invalid_code;
  sample_t qualified;
  sample_t median;
  logic    advance;
  logic    in_take;
  logic    stage_valid;

  logic [WINDOW_LEN-1:0][SAMPLE_W-1:0] window;
  logic [WINDOW_LEN-1:0][SAMPLE_W-1:0] feed;
  logic [WINDOW_LEN-1:0]               hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_valid_range <= MAX_VALID_RANGE_RST;
      invalid_code    <= INVALID_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_VALID_RANGE: max_valid_range <= cfg_data;
        REG_INVALID_CODE:    invalid_code    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;
  assign in_take  = s_tvalid && advance;

  // Replace zero and out-of-range readings
  assign qualified = ((s_tdata == '0) || (s_tdata > max_valid_range)) ? invalid_code : s_tdata;

  assign feed[0] = qualified;

  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    if (i > 0) begin : g_link
      assign feed[i] = window[i-1];
    end
    rsmf_cell #(
      .WINDOW_LEN (WINDOW_LEN),
      .POS        (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift_en   (in_take),
      .shift_in   (feed[i]),
      .window     (window),
      .sample     (window[i]),
      .median_hit (hit[i])
    );
  end

  always_comb begin
    median = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      if (hit[i]) begin
        median = median | window[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      m_tvalid    <= 1'b0;
    end else if (advance) begin
      stage_valid <= s_tvalid;
      m_tvalid    <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_valid) begin
      m_tdata <= median;
    end
  end

endmodule

[rtl/rsmf_checker.sv]
module rsmf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // Output register empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid high after reset");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Empty output side never blocks input
  a_ready: assert property (@(posedge clk) !m_tvalid |-> s_tready)
    else $error("input blocked with empty output");

  // Accepted request reaches the output register after the window stage
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> ##1 m_tvalid)
    else $error("result missing after request");

endmodule

bind range_sample_median_filter_core rsmf_checker u_rsmf_checker (.*);

[tb/sv/tb_top.sv]
module tb_top import rsmf_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN        = 5;
  localparam int CYCLE_CAP  = 200000;
  localparam int DRAIN_CAP  = 2000;
  localparam int N_RANDOM   = 1100;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [0:0]  cfg_index = REG_MAX_VALID_RANGE;
  logic [15:0] cfg_data  = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;

  // mirror of the block's registers and window
  sample_t range_limit;
  sample_t bad_code;
  sample_t window_mem [WIN];
  int      slot_ptr;

  sample_t median_q [$];
  int      fail_cnt;
  int      cycle_cnt;
  int      stall_left;
  bit      tx_idle_on;
  bit      rx_stall_on;

  range_sample_median_filter_core #(
    .WINDOW_LEN(WIN)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [15:0] raw_range
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // [15:0] median_range
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input int expd, input int got);
    $display("tb: %s expected %0d got %0d at cycle %0d", what, expd, got, cycle_cnt);
    fail_cnt++;
  endtask

  function automatic sample_t window_median();
    sample_t sorted [WIN];
    sample_t key;
    int      j;
    for (int i = 0; i < WIN; i++) sorted[i] = window_mem[i];
    for (int i = 1; i < WIN; i++) begin
      key = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > key) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    return sorted[(WIN-1)/2];
  endfunction

  // qualify the reading, store it and return the new median
  function automatic sample_t store_and_median(input sample_t raw);
    sample_t q;
    q = (raw == '0 || raw > range_limit) ? bad_code : raw;
    window_mem[slot_ptr] = q;
    slot_ptr = (slot_ptr + 1 >= WIN) ? 0 : slot_ptr + 1;
    return window_median();
  endfunction

  // receiver: stall in random bursts
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_stall_on && $urandom_range(0, 5) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (median_q.size() == 0) begin
        report_mismatch("median with no request pending:", -1, int'(m_tdata));
      end else if (m_tdata !== median_q[0]) begin
        report_mismatch("median_range", int'(median_q[0]), int'(m_tdata));
        void'(median_q.pop_front());
      end else begin
        void'(median_q.pop_front());
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_CAP) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb: timeout after %0d cycles", cycle_cnt);
    $display("tb: failure");
    $finish;
  end

  task automatic send_range(input sample_t raw);
    int gap;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= raw;
    do @(posedge clk); while (!s_tready);
    median_q.push_back(store_and_median(raw));
  endtask

  // drop valid and hold until every median has come back
  task automatic wait_for_medians();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    while (median_q.size() != 0 && waited < DRAIN_CAP) begin
      @(posedge clk);
      waited++;
    end
    if (median_q.size() != 0) begin
      report_mismatch("medians never delivered, count", 0, median_q.size());
      median_q.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input sample_t value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MAX_VALID_RANGE) range_limit = value;
    else bad_code = value;
  endtask

  task automatic set_filter(input sample_t limit, input sample_t code);
    wait_for_medians();
    write_reg(REG_MAX_VALID_RANGE, limit);
    write_reg(REG_INVALID_CODE, code);
  endtask

  function automatic sample_t pick_range();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3:       return range_limit;
      4:       return range_limit + 16'd1;
      5:       return sample_t'($urandom_range(0, 65535));
      6:       return (range_limit > 16'd8) ? range_limit - sample_t'($urandom_range(0, 8))
                                            : range_limit;
      default: return (range_limit == '0) ? sample_t'($urandom_range(0, 65535))
                                          : sample_t'($urandom_range(1, range_limit));
    endcase
  endfunction

  task automatic test_reset_defaults();
    range_limit = MAX_VALID_RANGE_RST;
    bad_code    = INVALID_CODE_RST;
    for (int i = 0; i < WIN; i++) window_mem[i] = '0;
    slot_ptr = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // early medians still see the zeros left by reset
    send_range(16'd0);
    send_range(16'd1);
    send_range(16'd2200);
    send_range(16'd2201);
    send_range(16'hFFFF);
    send_range(16'd500);
    send_range(16'd500);
  endtask

  task automatic test_register_extremes();
    set_filter(16'hFFFF, 16'd0);
    send_range(16'hFFFF);
    send_range(16'd0);
    send_range(16'd1);
    send_range(16'h8000);
    // zero limit turns every reading into the invalid code
    set_filter(16'd0, 16'd1234);
    send_range(16'd1);
    send_range(16'hFFFF);
    send_range(16'd0);
    // invalid code that lies inside the valid range sorts like any sample
    set_filter(16'd5000, 16'd1234);
    send_range(16'd1234);
    send_range(16'd1233);
    send_range(16'd1235);
    send_range(16'd4999);
    send_range(16'd5001);
    set_filter(16'd1, 16'hFFFF);
    send_range(16'd1);
    send_range(16'd2);
    send_range(16'd0);
  endtask

  task automatic test_random_stream();
    int      phases;
    int      per_phase;
    sample_t limit;
    sample_t code;
    phases    = 9;
    per_phase = N_RANDOM / phases;
    for (int p = 0; p < phases; p++) begin
      case (p)
        0:       begin limit = MAX_VALID_RANGE_RST; code = INVALID_CODE_RST; end
        1:       begin limit = 16'hFFFF;            code = 16'hFFFF;         end
        2:       begin limit = 16'd1;               code = 16'd0;            end
        3:       begin limit = 16'd0;               code = 16'h5A5A;         end
        default: begin
          limit = sample_t'($urandom_range(1, 65535));
          code  = sample_t'($urandom_range(0, 65535));
        end
      endcase
      set_filter(limit, code);
      // idle in most phases, none in the closing ones
      tx_idle_on  = (p < phases - 2) && (p % 3 != 1);
      rx_stall_on = (p < phases - 2) && (p % 3 != 2);
      for (int i = 0; i < per_phase; i++) send_range(pick_range());
    end
    tx_idle_on  = 1'b0;
    rx_stall_on = 1'b0;
  endtask

  initial begin
    fail_cnt    = 0;
    stall_left  = 0;
    tx_idle_on  = 1'b1;
    rx_stall_on = 1'b1;
    test_reset_defaults();
    test_register_extremes();
    test_random_stream();
    wait_for_medians();
    repeat (10) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
